[hdl/assert_macros.svh]
// assertion helpers, empty when built for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCSH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pcsh assertion failed");
`define PCSH_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("pcsh forbidden condition seen");
`else
`define PCSH_ASSERT(lbl, clk, rst_n, prop)
`define PCSH_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hdl/pcsh_pkg.sv]
`default_nettype none
package pcsh_pkg;

	localparam int PC_W       = 64;
	localparam int IDX_IN_W   = 16;
	localparam int OUT_CNT_W  = 32;
	localparam int STATUS_W   = 3;

	// hash constants
	localparam int PC_SHIFT   = 4;
	localparam int HASH_MUL_W = 11;
	localparam logic [HASH_MUL_W-1:0] HASH_MUL = 11'd1147;
	localparam int MUL_LO_W   = 32;

	// modulo reduction, bits consumed per cycle
	localparam int RED_BITS   = 8;
	localparam int RED_CYCLES = PC_W / RED_BITS;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED = 3'd0,
		ST_HIT     = 3'd1,
		ST_CLAIMED = 3'd2,
		ST_DROPPED = 3'd3,
		ST_READ    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDATA,
		S_HASH,
		S_PROBE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic pc_en;
		logic cnt_en;
	} tbl_wr_t;

endpackage
`default_nettype wire

[hdl/pcsh_ifs.sv]
`default_nettype none
interface pcsh_req_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [pcsh_pkg::PC_W-1:0]           sample_pc;
	logic [pcsh_pkg::IDX_IN_W-1:0]       slot_index;

	modport source(output valid, command, sample_pc, slot_index, input ready);
	modport sink(input valid, command, sample_pc, slot_index, output ready);
endinterface

interface pcsh_rsp_if;
	logic                                valid;
	logic                                ready;
	pcsh_pkg::status_t                   status;
	logic [pcsh_pkg::PC_W-1:0]           slot_pc;
	logic [pcsh_pkg::OUT_CNT_W-1:0]      slot_count;
	logic [pcsh_pkg::OUT_CNT_W-1:0]      total_samples;
	logic [pcsh_pkg::OUT_CNT_W-1:0]      dropped_samples;

	modport source(output valid, status, slot_pc, slot_count, total_samples,
		dropped_samples, input ready);
	modport sink(input valid, status, slot_pc, slot_count, total_samples,
		dropped_samples, output ready);
endinterface
`default_nettype wire

[hdl/pcsh_hash.sv]
`default_nettype none
module pcsh_hash #(
	parameter int SLOTS = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pcsh_pkg::PC_W-1:0]  pc,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   home
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;
	localparam int LO_W  = pcsh_pkg::MUL_LO_W;
	localparam int XH_W  = pcsh_pkg::PC_W - pcsh_pkg::PC_SHIFT - LO_W;
	localparam int PL_W  = LO_W + pcsh_pkg::HASH_MUL_W;
	localparam int PH_W  = XH_W + pcsh_pkg::HASH_MUL_W;

	logic              v_s1;
	logic [PL_W-1:0]   pl_s1;
	logic [LO_W-1:0]   ph_s1;
	logic [PL_W-1:0]   pl_full;
	logic [PH_W-1:0]   ph_full;
	logic [pcsh_pkg::PC_W-1:0] prod;

	// (pc >> 4) * 1147 split into two narrow partial products
	assign pl_full = PL_W'(pc[pcsh_pkg::PC_SHIFT +: LO_W]) * PL_W'(pcsh_pkg::HASH_MUL);
	assign ph_full = PH_W'(pc[pcsh_pkg::PC_W-1 -: XH_W]) * PH_W'(pcsh_pkg::HASH_MUL);
	assign prod    = {ph_s1, {LO_W{1'b0}}} + pcsh_pkg::PC_W'(pl_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		pl_s1 <= pl_full;
		ph_s1 <= ph_full[LO_W-1:0];
	end

	generate
		if (POW2) begin : g_pow2
			logic             v_s2;
			logic [IDX_W-1:0] home_s2;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s2 <= 1'b0;
				end else begin
					v_s2 <= v_s1;
				end
			end

			always_ff @(posedge clk) begin
				home_s2 <= prod[IDX_W-1:0];
			end

			assign done = v_s2;
			assign home = home_s2;
		end else begin : g_mod
			localparam int RC_W = $clog2(pcsh_pkg::RED_CYCLES);
			localparam logic [IDX_W:0] SLOTS_C = (IDX_W + 1)'(SLOTS);

			logic                      busy_q;
			logic                      done_q;
			logic [RC_W-1:0]           cnt_q;
			logic [pcsh_pkg::PC_W-1:0] sh_q;
			logic [IDX_W-1:0]          rem_q;
			logic [IDX_W-1:0]          rem_nxt;
			logic [IDX_W:0]            r;

			// msb-first remainder, one conditional subtract per bit
			always_comb begin
				r = '0;
				r[IDX_W-1:0] = rem_q;
				for (int i = 0; i < pcsh_pkg::RED_BITS; i++) begin
					r = {r[IDX_W-1:0], sh_q[pcsh_pkg::PC_W-1-i]};
					if (r >= SLOTS_C) begin
						r = r - SLOTS_C;
					end
				end
				rem_nxt = r[IDX_W-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b0;
					if (v_s1) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == RC_W'(pcsh_pkg::RED_CYCLES - 1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (v_s1) begin
					sh_q  <= prod;
					rem_q <= '0;
				end else if (busy_q) begin
					sh_q  <= sh_q << pcsh_pkg::RED_BITS;
					rem_q <= rem_nxt;
				end
			end

			assign done = done_q;
			assign home = rem_q;
		end
	endgenerate

endmodule
`default_nettype wire

[hdl/pcsh_table.sv]
`default_nettype none
module pcsh_table #(
	parameter int SLOTS      = 65536,
	parameter int COUNT_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       clr_busy,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output logic [pcsh_pkg::PC_W-1:0]  rd_pc,
	output logic [COUNT_BITS-1:0]      rd_cnt,
	input  pcsh_pkg::tbl_wr_t          wr,
	input  logic [$clog2(SLOTS)-1:0]   wr_addr,
	input  logic [pcsh_pkg::PC_W-1:0]  wr_pc,
	input  logic [COUNT_BITS-1:0]      wr_cnt
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [pcsh_pkg::PC_W-1:0] pc_mem  [SLOTS];
	logic [COUNT_BITS-1:0]     cnt_mem [SLOTS];

	logic                      clr_q;
	logic [IDX_W-1:0]          clr_addr_q;
	logic [pcsh_pkg::PC_W-1:0] rd_pc_q;
	logic [COUNT_BITS-1:0]     rd_cnt_q;

	// zero every pc entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(SLOTS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			pc_mem[clr_addr_q] <= '0;
		end else if (wr.pc_en) begin
			pc_mem[wr_addr] <= wr_pc;
		end
		rd_pc_q <= pc_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.cnt_en) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
		rd_cnt_q <= cnt_mem[rd_addr];
	end

	assign clr_busy = clr_q;
	assign rd_pc    = rd_pc_q;
	assign rd_cnt   = rd_cnt_q;

endmodule
`default_nettype wire

[hdl/pc_sample_histogram.sv]
// pc sampling histogram, open addressing with linear probing in one pc / count table
// a read goes S_RDATA, S_EMIT; an ignored sample S_EMIT; a recorded one S_HASH (serial
//   modulo unless SLOTS is a power of two), 1..MAX_PROBES probes in S_PROBE, S_EMIT
// one request at a time, next request taken once the result is in the output register
// the table port does one probe per cycle, so the probe walk sets the rate
// arst_n clears control and counters, then every pc table entry is swept to zero
`default_nettype none
`include "assert_macros.svh"
module pc_sample_histogram #(
	parameter int SLOTS      = 65536,
	parameter int MAX_PROBES = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	pcsh_req_if.sink    req,
	pcsh_rsp_if.source  rsp
);

	localparam int IDX_W     = $clog2(SLOTS);
	localparam int PRB_W     = $clog2(MAX_PROBES + 1);
	localparam int IDX_EXT_W = ((IDX_W > pcsh_pkg::IDX_IN_W) ? IDX_W : pcsh_pkg::IDX_IN_W) + 1;
	localparam int CNT_EXT_W = (COUNT_BITS > pcsh_pkg::OUT_CNT_W) ?
		COUNT_BITS : pcsh_pkg::OUT_CNT_W;

	// saturating increment for the slot counts and the two running totals
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// count as seen on the result, low 32 bits
	function automatic logic [pcsh_pkg::OUT_CNT_W-1:0] cnt_out(
		input logic [COUNT_BITS-1:0] v);
		logic [CNT_EXT_W-1:0] e;
		e = CNT_EXT_W'(v);
		return e[pcsh_pkg::OUT_CNT_W-1:0];
	endfunction

	// next probe slot, wrapping at the table end
	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] a);
		return (a == IDX_W'(SLOTS - 1)) ? '0 : a + 1'b1;
	endfunction

	pcsh_pkg::state_t state_q, state_d;

	logic                      enable_q;
	logic [pcsh_pkg::PC_W-1:0] pc_q;
	logic                      rd_ok_q;
	logic [IDX_W-1:0]          chk_addr_q;
	logic [IDX_W-1:0]          nxt_addr_q;
	logic [PRB_W-1:0]          chk_cnt_q;
	logic [COUNT_BITS-1:0]     total_q;
	logic [COUNT_BITS-1:0]     dropped_q;

	// result being built, then the output register
	pcsh_pkg::status_t         res_status_q;
	logic [pcsh_pkg::PC_W-1:0] res_pc_q;
	logic [COUNT_BITS-1:0]     res_cnt_q;

	logic                           out_valid_q;
	pcsh_pkg::status_t              out_status_q;
	logic [pcsh_pkg::PC_W-1:0]      out_pc_q;
	logic [pcsh_pkg::OUT_CNT_W-1:0] out_cnt_q;
	logic [pcsh_pkg::OUT_CNT_W-1:0] out_total_q;
	logic [pcsh_pkg::OUT_CNT_W-1:0] out_dropped_q;

	// handshake and control decoded from the state
	logic                      req_ready;
	logic                      accept;
	logic                      hash_start;
	logic                      hash_done;
	logic [IDX_W-1:0]          hash_home;
	logic                      clr_busy;
	logic [IDX_W-1:0]          rd_addr;
	logic [pcsh_pkg::PC_W-1:0] tbl_pc;
	logic [COUNT_BITS-1:0]     tbl_cnt;
	pcsh_pkg::tbl_wr_t         wr_ctl;
	logic [COUNT_BITS-1:0]     wr_cnt;
	logic                      total_inc;
	logic                      drop_inc;
	logic                      status_set;
	pcsh_pkg::status_t         status_d;
	logic                      probe_init;
	logic                      probe_adv;
	logic                      out_load;

	// read index may be wider or narrower than the table index
	logic [IDX_EXT_W-1:0]      idx_ext;
	logic                      in_range;
	logic [IDX_W-1:0]          in_addr;

	assign idx_ext  = IDX_EXT_W'(req.slot_index);
	assign in_range = idx_ext < IDX_EXT_W'(SLOTS);
	assign in_addr  = in_range ? idx_ext[IDX_W-1:0] : '0;
	assign accept   = req.valid && req_ready;

	pcsh_hash #(
		.SLOTS (SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.pc     (req.sample_pc),
		.done   (hash_done),
		.home   (hash_home)
	);

	pcsh_table #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_busy (clr_busy),
		.rd_addr  (rd_addr),
		.rd_pc    (tbl_pc),
		.rd_cnt   (tbl_cnt),
		.wr       (wr_ctl),
		.wr_addr  (chk_addr_q),
		.wr_pc    (pc_q),
		.wr_cnt   (wr_cnt)
	);

	// next state and control
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		hash_start = 1'b0;
		rd_addr    = nxt_addr_q;
		wr_ctl     = '0;
		wr_cnt     = sat_inc(tbl_cnt);
		total_inc  = 1'b0;
		drop_inc   = 1'b0;
		status_set = 1'b0;
		status_d   = pcsh_pkg::ST_IGNORED;
		probe_init = 1'b0;
		probe_adv  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			pcsh_pkg::S_IDLE: begin
				// no request while the table sweep is running
				req_ready = !clr_busy;
				rd_addr   = in_addr;
				if (req.valid && !clr_busy) begin
					if (req.command == pcsh_pkg::CMD_READ) begin
						state_d = pcsh_pkg::S_RDATA;
					end else if (enable_q && (req.sample_pc != '0)) begin
						hash_start = 1'b1;
						total_inc  = 1'b1;
						state_d    = pcsh_pkg::S_HASH;
					end else begin
						status_set = 1'b1;
						status_d   = pcsh_pkg::ST_IGNORED;
						state_d    = pcsh_pkg::S_EMIT;
					end
				end
			end
			pcsh_pkg::S_RDATA: begin
				status_set = 1'b1;
				status_d   = pcsh_pkg::ST_READ;
				state_d    = pcsh_pkg::S_EMIT;
			end
			pcsh_pkg::S_HASH: begin
				// home slot read issued the cycle the hash lands
				rd_addr = hash_home;
				if (hash_done) begin
					probe_init = 1'b1;
					state_d    = pcsh_pkg::S_PROBE;
				end
			end
			pcsh_pkg::S_PROBE: begin
				// data of chk_addr_q is here, next slot read goes out speculatively
				if (tbl_pc == pc_q) begin
					wr_ctl.cnt_en = 1'b1;
					status_set    = 1'b1;
					status_d      = pcsh_pkg::ST_HIT;
					state_d       = pcsh_pkg::S_EMIT;
				end else if (tbl_pc == '0) begin
					wr_ctl.pc_en  = 1'b1;
					wr_ctl.cnt_en = 1'b1;
					wr_cnt        = COUNT_BITS'(1);
					status_set    = 1'b1;
					status_d      = pcsh_pkg::ST_CLAIMED;
					state_d       = pcsh_pkg::S_EMIT;
				end else if (chk_cnt_q == PRB_W'(MAX_PROBES - 1)) begin
					drop_inc   = 1'b1;
					status_set = 1'b1;
					status_d   = pcsh_pkg::ST_DROPPED;
					state_d    = pcsh_pkg::S_EMIT;
				end else begin
					probe_adv = 1'b1;
				end
			end
			pcsh_pkg::S_EMIT: begin
				// wait for a free output register
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = pcsh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pcsh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcsh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sampling enable register and the two running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			total_q   <= '0;
			dropped_q <= '0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (total_inc) begin
				total_q <= sat_inc(total_q);
			end
			if (drop_inc) begin
				dropped_q <= sat_inc(dropped_q);
			end
		end
	end

	// request capture, probe walk and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q      <= req.sample_pc;
			rd_ok_q   <= in_range;
			res_pc_q  <= '0;
			res_cnt_q <= '0;
		end
		if (probe_init) begin
			chk_addr_q <= hash_home;
			nxt_addr_q <= slot_inc(hash_home);
			chk_cnt_q  <= '0;
		end else if (probe_adv) begin
			chk_addr_q <= nxt_addr_q;
			nxt_addr_q <= slot_inc(nxt_addr_q);
			chk_cnt_q  <= chk_cnt_q + 1'b1;
		end
		// an empty or out-of-range slot reads as zero
		if (state_q == pcsh_pkg::S_RDATA && rd_ok_q && (tbl_pc != '0)) begin
			res_pc_q  <= tbl_pc;
			res_cnt_q <= tbl_cnt;
		end
		if (status_set) begin
			res_status_q <= status_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_pc_q      <= res_pc_q;
			out_cnt_q     <= cnt_out(res_cnt_q);
			out_total_q   <= cnt_out(total_q);
			out_dropped_q <= cnt_out(dropped_q);
		end
	end

	assign req.ready           = req_ready;
	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.slot_pc         = out_pc_q;
	assign rsp.slot_count      = out_cnt_q;
	assign rsp.total_samples   = out_total_q;
	assign rsp.dropped_samples = out_dropped_q;

	// checks
	`PCSH_NEVER(a_no_req_during_clear, clk, arst_n, req_ready && clr_busy)
	`PCSH_NEVER(a_dropped_le_total, clk, arst_n, dropped_q > total_q)
	`PCSH_ASSERT(a_hash_done_in_hash, clk, arst_n, hash_done |-> state_q == pcsh_pkg::S_HASH)
	`PCSH_ASSERT(a_probe_bound, clk, arst_n,
		state_q == pcsh_pkg::S_PROBE |-> chk_cnt_q < PRB_W'(MAX_PROBES))
	`PCSH_NEVER(a_no_write_outside_probe, clk, arst_n,
		(wr_ctl.pc_en || wr_ctl.cnt_en) && state_q != pcsh_pkg::S_PROBE)

endmodule
`default_nettype wire
